@@ rtl/core/fm25519_pkg.sv @@
package fm25519_pkg;

  localparam int NLIMB   = 5;
  localparam int LIMB_W  = 51;
  localparam int IN_W    = 52;
  localparam int OUT1_W  = 52;
  localparam int HALF_W  = IN_W / 2;
  localparam int PROD_W  = 2 * IN_W;
  localparam int COL_W   = 112;
  localparam int CY_W    = COL_W - LIMB_W;
  localparam int FOLD_W  = CY_W + 5;
  localparam int MUL_LAT = 2;
  localparam int LAT     = MUL_LAT + 3 + NLIMB;

  typedef logic [IN_W-1:0]   in_limb_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [CY_W-1:0]   cy_t;

  // 2^255 = 19 mod p
  function automatic col_t times19(col_t x);
    return (x << 4) + (x << 1) + x;
  endfunction

endpackage

@@ rtl/core/fm25519_mul.sv @@
module fm25519_mul
  import fm25519_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  in_limb_t a,
  input  in_limb_t b,
  output prod_t    p
);

  logic [2*HALF_W-1:0] pp00;
  logic [2*HALF_W-1:0] pp01;
  logic [2*HALF_W-1:0] pp10;
  logic [2*HALF_W-1:0] pp11;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= a[HALF_W-1:0] * b[HALF_W-1:0];
      pp01 <= a[HALF_W-1:0] * b[IN_W-1:HALF_W];
      pp10 <= a[IN_W-1:HALF_W] * b[HALF_W-1:0];
      pp11 <= a[IN_W-1:HALF_W] * b[IN_W-1:HALF_W];
      p    <= PROD_W'(pp00)
            + (PROD_W'(pp01) << HALF_W)
            + (PROD_W'(pp10) << HALF_W)
            + (PROD_W'(pp11) << (2 * HALF_W));
    end
  end

endmodule

@@ rtl/core/field_mul_p25519_radix51.sv @@
// Throughput: one item per cycle; the whole pipeline holds while a valid output item is stalled.
// Stages: two for the 25 split 52x52 limb products, one column sum, one fold by 19,
// five carry stages (one column each), one final fold of the top carry into limb 0.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module field_mul_p25519_radix51
  import fm25519_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IN_W-1:0]      multiplicand_limb0,
  input  logic [IN_W-1:0]      multiplicand_limb1,
  input  logic [IN_W-1:0]      multiplicand_limb2,
  input  logic [IN_W-1:0]      multiplicand_limb3,
  input  logic [IN_W-1:0]      multiplicand_limb4,
  input  logic [IN_W-1:0]      multiplier_limb0,
  input  logic [IN_W-1:0]      multiplier_limb1,
  input  logic [IN_W-1:0]      multiplier_limb2,
  input  logic [IN_W-1:0]      multiplier_limb3,
  input  logic [IN_W-1:0]      multiplier_limb4,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LIMB_W-1:0]    product_limb0,
  output logic [OUT1_W-1:0]    product_limb1,
  output logic [LIMB_W-1:0]    product_limb2,
  output logic [LIMB_W-1:0]    product_limb3,
  output logic [LIMB_W-1:0]    product_limb4
);

  logic              en;
  logic [LAT-1:0]    vld;
  in_limb_t          a [NLIMB];
  in_limb_t          b [NLIMB];
  prod_t             prod [NLIMB*NLIMB];
  col_t              lo_next [NLIMB];
  col_t              hi_next [NLIMB-1];
  col_t              lo [NLIMB];
  col_t              hi [NLIMB-1];
  col_t              col_r [NLIMB][NLIMB];
  limb_t             limb_r [NLIMB+1][NLIMB];
  cy_t               cy_r [NLIMB+1];
  col_t              csum [NLIMB];
  logic [FOLD_W-1:0] fold;
  limb_t             out0;
  logic [OUT1_W-1:0] out1;
  limb_t             out2;
  limb_t             out3;
  limb_t             out4;

  assign en       = !(vld[LAT-1] && out_stall);
  assign in_stall = !en;

  assign a[0] = multiplicand_limb0;
  assign a[1] = multiplicand_limb1;
  assign a[2] = multiplicand_limb2;
  assign a[3] = multiplicand_limb3;
  assign a[4] = multiplicand_limb4;
  assign b[0] = multiplier_limb0;
  assign b[1] = multiplier_limb1;
  assign b[2] = multiplier_limb2;
  assign b[3] = multiplier_limb3;
  assign b[4] = multiplier_limb4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < NLIMB; i++) begin : g_row
    for (genvar j = 0; j < NLIMB; j++) begin : g_col
      fm25519_mul u_mul (
        .clk (clk),
        .en  (en),
        .a   (a[i]),
        .b   (b[j]),
        .p   (prod[i*NLIMB+j])
      );
    end
  end

  // low columns take i+j < 5, high columns i+j >= 5 wrap with weight 19
  always_comb begin
    for (int k = 0; k < NLIMB; k++) begin
      lo_next[k] = '0;
    end
    for (int k = 0; k < NLIMB-1; k++) begin
      hi_next[k] = '0;
    end
    for (int i = 0; i < NLIMB; i++) begin
      for (int j = 0; j < NLIMB; j++) begin
        if (i + j < NLIMB) begin
          lo_next[i+j] = lo_next[i+j] + COL_W'(prod[i*NLIMB+j]);
        end else begin
          hi_next[i+j-NLIMB] = hi_next[i+j-NLIMB] + COL_W'(prod[i*NLIMB+j]);
        end
      end
    end
  end

  always_comb begin
    for (int s = 0; s < NLIMB; s++) begin
      csum[s] = col_r[s][s] + COL_W'(cy_r[s]);
    end
    fold = FOLD_W'(limb_r[NLIMB][0])
         + (FOLD_W'(cy_r[NLIMB]) << 4)
         + (FOLD_W'(cy_r[NLIMB]) << 1)
         + FOLD_W'(cy_r[NLIMB]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo <= lo_next;
      hi <= hi_next;
      for (int k = 0; k < NLIMB-1; k++) begin
        col_r[0][k] <= lo[k] + times19(hi[k]);
      end
      col_r[0][NLIMB-1] <= lo[NLIMB-1];
      cy_r[0] <= '0;
      for (int k = 0; k < NLIMB; k++) begin
        limb_r[0][k] <= '0;
      end
      for (int s = 0; s < NLIMB-1; s++) begin
        for (int k = 0; k < NLIMB; k++) begin
          col_r[s+1][k] <= col_r[s][k];
        end
      end
      // carry through one column per stage
      for (int s = 0; s < NLIMB; s++) begin
        for (int k = 0; k < NLIMB; k++) begin
          if (k == s) begin
            limb_r[s+1][k] <= csum[s][LIMB_W-1:0];
          end else begin
            limb_r[s+1][k] <= limb_r[s][k];
          end
        end
        cy_r[s+1] <= csum[s][COL_W-1:LIMB_W];
      end
      out0 <= fold[LIMB_W-1:0];
      out1 <= OUT1_W'(limb_r[NLIMB][1]) + OUT1_W'(fold[FOLD_W-1:LIMB_W]);
      out2 <= limb_r[NLIMB][2];
      out3 <= limb_r[NLIMB][3];
      out4 <= limb_r[NLIMB][4];
    end
  end

  assign out_valid     = vld[LAT-1];
  assign product_limb0 = out0;
  assign product_limb1 = out1;
  assign product_limb2 = out2;
  assign product_limb3 = out3;
  assign product_limb4 = out4;

endmodule

@@ rtl/core/fm25519_chk.sv @@
module fm25519_chk
  import fm25519_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [LIMB_W-1:0] product_limb0,
  input logic [OUT1_W-1:0] product_limb1,
  input logic [LIMB_W-1:0] product_limb2,
  input logic [LIMB_W-1:0] product_limb3,
  input logic [LIMB_W-1:0] product_limb4
);

  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(product_limb0)
      && $stable(product_limb1) && $stable(product_limb2)
      && $stable(product_limb3) && $stable(product_limb4)))
    else $error("stalled output item changed");

endmodule

bind field_mul_p25519_radix51 fm25519_chk u_chk (.*);

@@ sim/field_mul_p25519_radix51_tb.sv @@
`timescale 1ns / 1ps

module field_mul_p25519_radix51_tb;
  import fm25519_pkg::*;

  localparam int FOLD_FACTOR  = 19;
  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [63:0] LIMB_MASK64 = (64'd1 << LIMB_W) - 64'd1;

  typedef enum logic [2:0] {
    PH_FREE,
    PH_SRC_IDLE,
    PH_SNK_STALL,
    PH_BOTH,
    PH_HOLD,
    PH_TAIL
  } phase_t;

  typedef struct packed {
    in_limb_t [NLIMB-1:0] mcand;
    in_limb_t [NLIMB-1:0] mplier;
  } mul_item_t;

  typedef struct packed {
    limb_t             l0;
    logic [OUT1_W-1:0] l1;
    limb_t             l2;
    limb_t             l3;
    limb_t             l4;
  } mul_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  mul_item_t         bus_op = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  limb_t             product_limb0;
  logic [OUT1_W-1:0] product_limb1;
  limb_t             product_limb2;
  limb_t             product_limb3;
  limb_t             product_limb4;

  mul_item_t   pending_ops[$];
  mul_result_t awaited_products[$];
  int          sent_count = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  logic        hold_used = 1'b0;
  phase_t      phase;

  field_mul_p25519_radix51 dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .multiplicand_limb0(bus_op.mcand[0]),
    .multiplicand_limb1(bus_op.mcand[1]),
    .multiplicand_limb2(bus_op.mcand[2]),
    .multiplicand_limb3(bus_op.mcand[3]),
    .multiplicand_limb4(bus_op.mcand[4]),
    .multiplier_limb0  (bus_op.mplier[0]),
    .multiplier_limb1  (bus_op.mplier[1]),
    .multiplier_limb2  (bus_op.mplier[2]),
    .multiplier_limb3  (bus_op.mplier[3]),
    .multiplier_limb4  (bus_op.mplier[4]),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .product_limb0     (product_limb0),
    .product_limb1     (product_limb1),
    .product_limb2     (product_limb2),
    .product_limb3     (product_limb3),
    .product_limb4     (product_limb4)
  );

  function automatic mul_result_t mul_mod_p(mul_item_t op);
    logic [127:0] col [NLIMB];
    logic [63:0]  limb [NLIMB];
    logic [63:0]  cy;
    logic [63:0]  b19;
    mul_result_t  r;
    int           k;
    for (int i = 0; i < NLIMB; i++) begin
      col[i] = '0;
    end
    for (int i = 0; i < NLIMB; i++) begin
      for (int j = 0; j < NLIMB; j++) begin
        k = i + j;
        if (k < NLIMB) begin
          col[k] = col[k] + 128'(op.mcand[i]) * 128'(op.mplier[j]);
        end else begin
          b19 = 64'(op.mplier[j]) * 64'(FOLD_FACTOR);
          col[k-NLIMB] = col[k-NLIMB] + 128'(op.mcand[i]) * 128'(b19);
        end
      end
    end
    cy = '0;
    for (int i = 0; i < NLIMB; i++) begin
      col[i] = col[i] + 128'(cy);
      cy = col[i][LIMB_W+63:LIMB_W];
      limb[i] = 64'(col[i][LIMB_W-1:0]);
    end
    limb[0] = limb[0] + cy * 64'(FOLD_FACTOR);
    limb[1] = limb[1] + (limb[0] >> LIMB_W);
    limb[0] = limb[0] & LIMB_MASK64;
    r.l0 = limb[0][LIMB_W-1:0];
    r.l1 = limb[1][OUT1_W-1:0];
    r.l2 = limb[2][LIMB_W-1:0];
    r.l3 = limb[3][LIMB_W-1:0];
    r.l4 = limb[4][LIMB_W-1:0];
    return r;
  endfunction

  function automatic in_limb_t rand_limb();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(7))
      0, 1, 2: return w[IN_W-1:0];
      3:       return {1'b0, w[LIMB_W-1:0]};
      4:       return '1;
      5:       return in_limb_t'(LIMB_MASK64);
      6:       return in_limb_t'($urandom_range(255));
      default: return {4'hf, w[IN_W-5:0]};
    endcase
  endfunction

  function automatic mul_item_t uniform_op(in_limb_t a, in_limb_t b);
    mul_item_t op;
    for (int i = 0; i < NLIMB; i++) begin
      op.mcand[i]  = a;
      op.mplier[i] = b;
    end
    return op;
  endfunction

  function automatic int src_idle_pct(phase_t ph);
    case (ph)
      PH_SRC_IDLE: return 81;
      PH_BOTH:     return 21;
      default:     return 0;
    endcase
  endfunction

  function automatic int snk_stall_pct(phase_t ph);
    case (ph)
      PH_SNK_STALL: return 81;
      PH_BOTH:      return 21;
      default:      return 0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  always_comb begin
    if (sent_count < 100) phase = PH_FREE;
    else if (sent_count < 200) phase = PH_SRC_IDLE;
    else if (sent_count < 300) phase = PH_SNK_STALL;
    else if (sent_count < 400) phase = PH_BOTH;
    else if (sent_count < 480) phase = PH_HOLD;
    else phase = PH_TAIL;
  end

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // drive items
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_products.push_back(mul_mod_p(bus_op));
        sent_count <= sent_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= src_idle_pct(phase)) begin
          bus_op   <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // hold off the output for a long stretch once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (phase == PH_HOLD && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(99) < snk_stall_pct(phase));
    end
  end

  always @(posedge clk) begin : check_products
    mul_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_products.size() == 0) begin
        report_mismatch("unexpected item limb0", 64'(product_limb0), '0);
      end else begin
        want = awaited_products.pop_front();
        if (product_limb0 !== want.l0)
          report_mismatch("product_limb0", 64'(product_limb0), 64'(want.l0));
        if (product_limb1 !== want.l1)
          report_mismatch("product_limb1", 64'(product_limb1), 64'(want.l1));
        if (product_limb2 !== want.l2)
          report_mismatch("product_limb2", 64'(product_limb2), 64'(want.l2));
        if (product_limb3 !== want.l3)
          report_mismatch("product_limb3", 64'(product_limb3), 64'(want.l3));
        if (product_limb4 !== want.l4)
          report_mismatch("product_limb4", 64'(product_limb4), 64'(want.l4));
      end
    end
  end

  initial begin
    mul_item_t op;
    mul_item_t p_op;
    in_limb_t  lmax;
    in_limb_t  l51;

    lmax = '1;
    l51  = in_limb_t'(LIMB_MASK64);
    p_op = uniform_op(l51, l51);
    p_op.mcand[0]  = l51 - in_limb_t'(FOLD_FACTOR - 1);
    p_op.mplier[0] = l51 - in_limb_t'(FOLD_FACTOR - 1);

    pending_ops.push_back(uniform_op('0, '0));
    pending_ops.push_back(uniform_op(lmax, lmax));
    pending_ops.push_back(uniform_op(l51, l51));
    pending_ops.push_back(uniform_op(l51 + in_limb_t'(1), l51 + in_limb_t'(1)));
    pending_ops.push_back(uniform_op(lmax, '0));
    op = uniform_op('0, lmax);
    op.mcand[0] = in_limb_t'(1);
    pending_ops.push_back(op);
    op = p_op;
    op.mplier = '0;
    op.mplier[0] = in_limb_t'(1);
    pending_ops.push_back(op);
    pending_ops.push_back(p_op);
    op = p_op;
    op.mplier = '1;
    pending_ops.push_back(op);
    for (int k = 0; k < NLIMB; k++) begin
      op = uniform_op('0, lmax);
      op.mcand[k] = lmax;
      pending_ops.push_back(op);
    end
    pending_ops.push_back(uniform_op({13{4'ha}}, {13{4'h5}}));
    pending_ops.push_back(uniform_op({13{4'h5}}, {13{4'ha}}));
    op = uniform_op('0, '0);
    op.mcand[4]  = lmax;
    op.mplier[4] = lmax;
    pending_ops.push_back(op);
    op = uniform_op('0, '0);
    op.mcand[0]  = lmax;
    op.mplier[1] = l51 + in_limb_t'(1);
    pending_ops.push_back(op);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      for (int k = 0; k < NLIMB; k++) begin
        op.mcand[k]  = rand_limb();
        op.mplier[k] = rand_limb();
      end
      pending_ops.push_back(op);
    end

    @(posedge clk);
    while (pending_ops.size() != 0 || in_valid || awaited_products.size() != 0) begin
      @(posedge clk);
    end
    repeat (2 * LAT) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
